### rtl/imu_cf_pkg.sv
`timescale 1ns / 1ps
// Constants, register codes and the arctangent table for the IMU tilt filter.
// Used by imu_tilt_complementary_filter_core; depends on nothing.
package imu_cf_pkg;

    localparam int CORDIC_STEPS  = 16;
    localparam int ATAN_ENTRIES  = 24;
    localparam int CORDIC_ITERS  = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
    localparam int CNT_W         = $clog2(CORDIC_ITERS);

    localparam int DEG180_FINE   = 11796480;
    localparam int DEG90_COARSE  = 23040;
    localparam int DEG180_COARSE = 46080;

    localparam int DIV_RATE      = 131;
    localparam int RATE_HALF     = 65;
    localparam int RECIP_RATE    = 256140;
    localparam int RATE_SHIFT    = 25;

    localparam int DIV_DELTA     = 125;
    localparam int DELTA_HALF    = 500;
    localparam int DELTA_PRESH   = 3;
    localparam int RECIP_DELTA   = 34359738;
    localparam int DELTA_SHIFT   = 32;

    localparam int MIX_SHIFT     = 15;
    localparam int MIX_HALF      = 16384;

    localparam int GYRO_WEIGHT_RESET  = 31949;
    localparam int ACCEL_WEIGHT_RESET = 819;

    typedef enum logic [1:0] {
        REG_GYRO_WEIGHT   = 2'd0,
        REG_ACCEL_WEIGHT  = 2'd1,
        REG_GYRO_X_OFFSET = 2'd2,
        REG_GYRO_Z_OFFSET = 2'd3
    } t_reg_idx;

    function automatic logic signed [26:0] atan_fine(input logic [4:0] idx);
        case (idx)
            5'd0:    return 27'sd2949120;
            5'd1:    return 27'sd1740967;
            5'd2:    return 27'sd919879;
            5'd3:    return 27'sd466945;
            5'd4:    return 27'sd234379;
            5'd5:    return 27'sd117304;
            5'd6:    return 27'sd58666;
            5'd7:    return 27'sd29335;
            5'd8:    return 27'sd14668;
            5'd9:    return 27'sd7334;
            5'd10:   return 27'sd3667;
            5'd11:   return 27'sd1833;
            5'd12:   return 27'sd917;
            5'd13:   return 27'sd458;
            5'd14:   return 27'sd229;
            5'd15:   return 27'sd115;
            5'd16:   return 27'sd57;
            5'd17:   return 27'sd29;
            5'd18:   return 27'sd14;
            5'd19:   return 27'sd7;
            5'd20:   return 27'sd4;
            5'd21:   return 27'sd2;
            5'd22:   return 27'sd1;
            default: return 27'sd0;
        endcase
    endfunction

endpackage

### rtl/imu_tilt_complementary_filter_core.sv
`timescale 1ns / 1ps
// Complementary tilt filter: CORDIC accelerometer tilt, gyro rate scaling,
// saturating integration and Q15 fusion on one shared multiplier. Uses imu_cf_pkg.
//
// A sample is accepted only in the idle state; the first sample after reset skips
// integration and fusion and takes its accelerometer tilt as the fused angle. The
// result turns valid in the same cycle as the block goes idle for the next sample. The CORDIC runs one
// micro-rotation per cycle on a shift-add unit; the gyro scaling, the two
// integration steps and the fusion run one after another through a single
// 34x27 multiplier, with divisions by 131 and 1000 done as reciprocal multiplies
// and one correction step. The input stalls while a sample is in progress; a
// finished result sits in the output register and holds the sequencer only at its
// last step if the previous result has not been taken. Configuration registers sit
// at byte addresses 0, 4, 8 and 12 and must be written while the block is idle.
module imu_tilt_complementary_filter_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic signed [15:0]  i_acc_x_raw,
    input  logic signed [15:0]  i_acc_y_raw,
    input  logic signed [15:0]  i_acc_z_raw,
    input  logic signed [15:0]  i_gyro_x_raw,
    input  logic signed [15:0]  i_gyro_z_raw,
    input  logic [15:0]         i_elapsed_ms,
    output logic                o_valid,
    input  logic                i_stall,
    output logic signed [31:0]  o_angle_x,
    output logic signed [31:0]  o_angle_z,
    output logic signed [16:0]  o_accel_angle_x,
    output logic signed [31:0]  o_gyro_x_angle,
    output logic signed [18:0]  o_rate_x,
    output logic signed [18:0]  o_rate_z
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CORDIC,
        S_ACC,
        S_RX,
        S_RZ,
        S_DXP,
        S_DXR,
        S_DXF,
        S_DZR,
        S_DZF,
        S_MIX1,
        S_MIX2,
        S_FUSE,
        S_DONE
    } t_state;

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = 17'(v);
        return v[15] ? 17'(-e) : 17'(e);
    endfunction

    function automatic logic [17:0] abs19(input logic signed [18:0] v);
        logic signed [18:0] m;
        m = v[18] ? -v : v;
        return m[17:0];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [50:0] v);
        if (v > 51'sd2147483647) begin
            return 32'sh7FFF_FFFF;
        end
        if (v < -51'sd2147483648) begin
            return 32'sh8000_0000;
        end
        return v[31:0];
    endfunction

    // configuration
    logic [15:0]        r_gyro_weight;
    logic [15:0]        r_accel_weight;
    logic signed [16:0] r_gyro_x_offset;
    logic signed [16:0] r_gyro_z_offset;
    logic               w_cfg_wr;

    // sequencer and datapath
    t_state                   r_state;
    logic [imu_cf_pkg::CNT_W-1:0] r_cnt;
    logic signed [27:0]       r_cx;
    logic signed [27:0]       r_cy;
    logic signed [26:0]       r_cz;
    logic                     r_x_neg;
    logic                     r_x_zero;
    logic                     r_y_zero;
    logic                     r_y_pos;
    logic signed [15:0]       r_gx;
    logic signed [15:0]       r_gz;
    logic [15:0]              r_dt;
    logic signed [16:0]       r_acc;
    logic signed [18:0]       r_rx;
    logic signed [18:0]       r_rz;
    logic signed [24:0]       r_dx;
    logic signed [24:0]       r_dz;
    logic [31:0]              r_num;
    logic signed [60:0]       r_prod;
    logic signed [49:0]       r_mix;
    logic signed [31:0]       r_fused;
    logic signed [31:0]       r_int_x;
    logic signed [31:0]       r_int_z;
    logic                     r_primed;

    // output register
    logic                     r_out_valid;
    logic signed [31:0]       r_out_angle_x;
    logic signed [31:0]       r_out_angle_z;
    logic signed [16:0]       r_out_accel;
    logic signed [31:0]       r_out_gyro_x;
    logic signed [18:0]       r_out_rate_x;
    logic signed [18:0]       r_out_rate_z;

    // input capture
    logic [16:0]        w_ax_abs;
    logic signed [17:0] w_den;
    logic signed [17:0] w_den_mag;
    logic signed [16:0] w_num0;

    // cordic
    logic signed [27:0] w_xs;
    logic signed [27:0] w_ys;
    logic signed [26:0] w_atan;
    logic               w_cy_pos;
    logic signed [27:0] n_cx;
    logic signed [27:0] n_cy;
    logic signed [26:0] n_cz;

    // tilt finish
    logic signed [26:0] w_half_turn;
    logic signed [26:0] w_z_adj;
    logic signed [26:0] w_z_rnd;
    logic signed [26:0] w_z_sh;
    logic signed [16:0] n_acc;

    // shared multiplier
    logic signed [33:0] w_mul_a;
    logic signed [26:0] w_mul_b;
    logic signed [60:0] w_mul_p;

    // quotient correction
    logic               w_is_rate;
    logic [25:0]        w_nx;
    logic [25:0]        w_nz;
    logic [25:0]        w_q0;
    logic [33:0]        w_fix_num;
    logic [33:0]        w_fix_rem;
    logic [25:0]        w_q;
    logic               w_fix_neg;
    logic signed [26:0] w_sq;
    logic signed [16:0] w_offset;
    logic signed [18:0] n_rate;
    logic signed [24:0] n_delta;
    logic [31:0]        n_num;

    // integration and fusion
    logic signed [31:0] n_int_x;
    logic signed [31:0] n_int_z;
    logic signed [49:0] w_mix_rnd;
    logic signed [49:0] w_mix_sh;
    logic signed [31:0] n_fused;
    logic               w_out_load;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_weight   <= 16'(imu_cf_pkg::GYRO_WEIGHT_RESET);
            r_accel_weight  <= 16'(imu_cf_pkg::ACCEL_WEIGHT_RESET);
            r_gyro_x_offset <= '0;
            r_gyro_z_offset <= '0;
        end else if (w_cfg_wr) begin
            unique case (imu_cf_pkg::t_reg_idx'(paddr[3:2]))
                imu_cf_pkg::REG_GYRO_WEIGHT:   r_gyro_weight   <= pwdata[15:0];
                imu_cf_pkg::REG_ACCEL_WEIGHT:  r_accel_weight  <= pwdata[15:0];
                imu_cf_pkg::REG_GYRO_X_OFFSET: r_gyro_x_offset <= pwdata[16:0];
                imu_cf_pkg::REG_GYRO_Z_OFFSET: r_gyro_z_offset <= pwdata[16:0];
            endcase
        end
    end

    always_comb begin
        unique case (imu_cf_pkg::t_reg_idx'(paddr[3:2]))
            imu_cf_pkg::REG_GYRO_WEIGHT:   prdata = {16'b0, r_gyro_weight};
            imu_cf_pkg::REG_ACCEL_WEIGHT:  prdata = {16'b0, r_accel_weight};
            imu_cf_pkg::REG_GYRO_X_OFFSET: prdata = 32'(r_gyro_x_offset);
            imu_cf_pkg::REG_GYRO_Z_OFFSET: prdata = 32'(r_gyro_z_offset);
        endcase
    end

    // ---------------------------------------------------------------------
    // Input capture: denominator az + |ax|, folded into the right half plane
    // ---------------------------------------------------------------------
    assign w_ax_abs  = abs16(i_acc_x_raw);
    assign w_den     = 18'(i_acc_z_raw) + $signed({1'b0, w_ax_abs});
    assign w_den_mag = w_den[17] ? -w_den : w_den;
    assign w_num0    = w_den[17] ? -17'(i_acc_y_raw) : 17'(i_acc_y_raw);

    // ---------------------------------------------------------------------
    // CORDIC micro-rotation
    // ---------------------------------------------------------------------
    assign w_xs     = r_cx >>> r_cnt;
    assign w_ys     = r_cy >>> r_cnt;
    assign w_atan   = imu_cf_pkg::atan_fine(5'(r_cnt));
    assign w_cy_pos = !r_cy[27] && (r_cy != '0);

    always_comb begin
        if (w_cy_pos) begin
            n_cx = r_cx + w_ys;
            n_cy = r_cy - w_xs;
            n_cz = r_cz + w_atan;
        end else begin
            n_cx = r_cx - w_ys;
            n_cy = r_cy + w_xs;
            n_cz = r_cz - w_atan;
        end
    end

    // ---------------------------------------------------------------------
    // Tilt finish: quadrant fix, round to 1/256 degree, clamp
    // ---------------------------------------------------------------------
    assign w_half_turn = r_y_pos ? 27'(imu_cf_pkg::DEG180_FINE)
                                 : -27'(imu_cf_pkg::DEG180_FINE);
    assign w_z_adj     = r_x_neg ? r_cz + w_half_turn : r_cz;
    assign w_z_rnd     = w_z_adj + (w_z_adj[26] ? 27'sd127 : 27'sd128);
    assign w_z_sh      = w_z_rnd >>> 8;

    always_comb begin
        if (r_y_zero) begin
            n_acc = r_x_neg ? 17'(imu_cf_pkg::DEG180_COARSE) : 17'sd0;
        end else if (r_x_zero) begin
            n_acc = r_y_pos ? 17'(imu_cf_pkg::DEG90_COARSE)
                            : -17'(imu_cf_pkg::DEG90_COARSE);
        end else if (w_z_sh > 27'(imu_cf_pkg::DEG180_COARSE)) begin
            n_acc = 17'(imu_cf_pkg::DEG180_COARSE);
        end else if (w_z_sh < -27'(imu_cf_pkg::DEG180_COARSE)) begin
            n_acc = -17'(imu_cf_pkg::DEG180_COARSE);
        end else begin
            n_acc = w_z_sh[16:0];
        end
    end

    // ---------------------------------------------------------------------
    // Reciprocal-multiply division with one correction step
    // ---------------------------------------------------------------------
    assign w_nx      = {abs16(r_gx), 9'b0} + 26'(imu_cf_pkg::RATE_HALF);
    assign w_nz      = {abs16(r_gz), 9'b0} + 26'(imu_cf_pkg::RATE_HALF);
    assign w_is_rate = (r_state == S_RX) || (r_state == S_RZ);
    assign w_q0      = w_is_rate ? r_prod[imu_cf_pkg::RATE_SHIFT +: 26]
                                 : r_prod[imu_cf_pkg::DELTA_SHIFT +: 26];

    always_comb begin
        unique case (r_state)
            S_RX: begin
                w_fix_num = 34'(w_nx);
                w_fix_neg = r_gx[15];
            end
            S_RZ: begin
                w_fix_num = 34'(w_nz);
                w_fix_neg = r_gz[15];
            end
            S_DXF: begin
                w_fix_num = 34'(r_num);
                w_fix_neg = r_rx[18];
            end
            S_DZF: begin
                w_fix_num = 34'(r_num);
                w_fix_neg = r_rz[18];
            end
            default: begin
                w_fix_num = 34'(r_num);
                w_fix_neg = 1'b0;
            end
        endcase
    end

    assign w_fix_rem = w_fix_num - (w_is_rate ? 34'(w_q0) * 34'(imu_cf_pkg::DIV_RATE)
                                              : 34'(w_q0) * 34'(imu_cf_pkg::DIV_DELTA));
    assign w_q       = w_q0 + 26'(w_fix_rem >= (w_is_rate ? 34'(imu_cf_pkg::DIV_RATE)
                                                          : 34'(imu_cf_pkg::DIV_DELTA)));
    assign w_sq      = w_fix_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});
    assign w_offset  = (r_state == S_RX) ? r_gyro_x_offset : r_gyro_z_offset;
    assign n_rate    = 19'(w_sq - 27'(w_offset));
    assign n_delta   = 25'(w_sq);
    assign n_num     = 32'((r_prod[33:0] + 34'(imu_cf_pkg::DELTA_HALF))
                           >> imu_cf_pkg::DELTA_PRESH);

    // ---------------------------------------------------------------------
    // Shared multiplier operand select
    // ---------------------------------------------------------------------
    always_comb begin
        unique case (r_state)
            S_ACC: begin
                w_mul_a = $signed({8'b0, w_nx});
                w_mul_b = 27'(imu_cf_pkg::RECIP_RATE);
            end
            S_RX: begin
                w_mul_a = $signed({8'b0, w_nz});
                w_mul_b = 27'(imu_cf_pkg::RECIP_RATE);
            end
            S_DXP: begin
                w_mul_a = $signed({16'b0, abs19(r_rx)});
                w_mul_b = $signed({11'b0, r_dt});
            end
            S_DXR, S_DZR: begin
                w_mul_a = $signed({2'b0, n_num});
                w_mul_b = 27'(imu_cf_pkg::RECIP_DELTA);
            end
            S_DXF: begin
                w_mul_a = $signed({16'b0, abs19(r_rz)});
                w_mul_b = $signed({11'b0, r_dt});
            end
            S_DZF: begin
                w_mul_a = 34'(r_fused) + 34'(r_dx);
                w_mul_b = $signed({11'b0, r_gyro_weight});
            end
            S_MIX1: begin
                w_mul_a = 34'(r_acc);
                w_mul_b = $signed({11'b0, r_accel_weight});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p = w_mul_a * w_mul_b;

    // ---------------------------------------------------------------------
    // Integration and fusion
    // ---------------------------------------------------------------------
    assign n_int_x   = sat32(51'(r_int_x) + 51'(r_dx));
    assign n_int_z   = sat32(51'(r_int_z) + 51'(r_dz));
    assign w_mix_rnd = r_mix + (r_mix[49] ? 50'(imu_cf_pkg::MIX_HALF - 1)
                                          : 50'(imu_cf_pkg::MIX_HALF));
    assign w_mix_sh  = w_mix_rnd >>> imu_cf_pkg::MIX_SHIFT;
    assign n_fused   = sat32(51'(w_mix_sh));

    assign w_out_load = (r_state == S_DONE) && (!r_out_valid || !i_stall);

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_p;
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_fused     <= '0;
            r_int_x     <= '0;
            r_int_z     <= '0;
            r_primed    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cx     <= $signed({2'b0, w_den_mag, 8'b0});
                        r_cy     <= $signed({{3{w_num0[16]}}, w_num0, 8'b0});
                        r_cz     <= '0;
                        r_cnt    <= '0;
                        r_x_neg  <= w_den[17];
                        r_x_zero <= (w_den == '0);
                        r_y_zero <= (i_acc_y_raw == '0);
                        r_y_pos  <= !i_acc_y_raw[15] && (i_acc_y_raw != '0);
                        r_gx     <= i_gyro_x_raw;
                        r_gz     <= i_gyro_z_raw;
                        r_dt     <= i_elapsed_ms;
                        r_state  <= S_CORDIC;
                    end
                end
                S_CORDIC: begin
                    r_cx <= n_cx;
                    r_cy <= n_cy;
                    r_cz <= n_cz;
                    if (r_cnt == imu_cf_pkg::CNT_W'(imu_cf_pkg::CORDIC_ITERS - 1)) begin
                        r_state <= S_ACC;
                    end else begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                S_ACC: begin
                    r_acc   <= n_acc;
                    r_state <= S_RX;
                end
                S_RX: begin
                    r_rx    <= n_rate;
                    r_state <= S_RZ;
                end
                S_RZ: begin
                    r_rz <= n_rate;
                    if (!r_primed) begin
                        r_fused  <= 32'(r_acc);
                        r_primed <= 1'b1;
                        r_state  <= S_DONE;
                    end else begin
                        r_state <= S_DXP;
                    end
                end
                S_DXP: begin
                    r_state <= S_DXR;
                end
                S_DXR: begin
                    r_num   <= n_num;
                    r_state <= S_DXF;
                end
                S_DXF: begin
                    r_dx    <= n_delta;
                    r_state <= S_DZR;
                end
                S_DZR: begin
                    r_num   <= n_num;
                    r_int_x <= n_int_x;
                    r_state <= S_DZF;
                end
                S_DZF: begin
                    r_dz    <= n_delta;
                    r_state <= S_MIX1;
                end
                S_MIX1: begin
                    r_mix   <= 50'(r_prod);
                    r_int_z <= n_int_z;
                    r_state <= S_MIX2;
                end
                S_MIX2: begin
                    r_mix   <= r_mix + 50'(r_prod);
                    r_state <= S_FUSE;
                end
                S_FUSE: begin
                    r_fused <= n_fused;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_load) begin
                        r_out_angle_x <= r_fused;
                        r_out_angle_z <= r_int_z;
                        r_out_accel   <= r_acc;
                        r_out_gyro_x  <= r_int_x;
                        r_out_rate_x  <= r_rx;
                        r_out_rate_z  <= r_rz;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_valid;
    assign o_angle_x       = r_out_angle_x;
    assign o_angle_z       = r_out_angle_z;
    assign o_accel_angle_x = r_out_accel;
    assign o_gyro_x_angle  = r_out_gyro_x;
    assign o_rate_x        = r_out_rate_x;
    assign o_rate_z        = r_out_rate_z;

endmodule
